// ===== design/luhn_card_number_classifier_unit_defines.svh =====
// Assertion macros for the Luhn card number classifier.
// Included by the top level; no other dependencies.
`ifndef LUHN_CARD_NUMBER_CLASSIFIER_UNIT_DEFINES_SVH
`define LUHN_CARD_NUMBER_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Condition a implies condition b in the same cycle.
`define LCC_ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);
// Condition a implies condition b in the next cycle.
`define LCC_ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);
`else
`define LCC_ASSERT_IMPLY(label, clk, rst, a, b, msg)
`define LCC_ASSERT_NEXT(label, clk, rst, a, b, msg)
`endif
`endif

// ===== design/luhn_pkg.sv =====
// Shared constants, types and codes for the Luhn card number classifier.
// No dependencies.
package luhn_pkg;

  localparam int CARD_W     = 54;
  localparam int NUM_DIGITS = 17;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int POS_W      = 5;
  localparam int IN_TDATA_W = 56;
  localparam int OUT_TDATA_W = 8;

  // Network kind codes.
  localparam logic [1:0] KIND_INVALID = 2'd0;
  localparam logic [1:0] KIND_FOUR    = 2'd1;
  localparam logic [1:0] KIND_FIVE    = 2'd2;
  localparam logic [1:0] KIND_THREE   = 2'd3;

  // Control from the sequencer to the digit converter.
  typedef struct packed {
    logic load;
    logic dabble;
    logic digit_shift;
  } conv_ctrl_t;

  // Results gathered by the digit scanner.
  typedef struct packed {
    logic [3:0]       sum_mod10;
    logic [POS_W-1:0] ndig;
    logic [3:0]       lead_hi;
    logic [3:0]       lead_lo;
  } scan_result_t;

endpackage

// ===== design/luhn_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift and add three) with a digit
// shift-out mode. Depends on luhn_pkg.
module luhn_bcd_conv
  import luhn_pkg::*;
(
  input  logic              clk,
  input  logic [CARD_W-1:0] card_number,
  input  conv_ctrl_t        ctrl,
  output logic [3:0]        digit
);

  logic [CARD_W-1:0] bin;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  // Load, shift one binary bit in, or shift one digit out toward the scanner.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= card_number;
      bcd <= '0;
    end else if (ctrl.dabble) begin
      bin <= {bin[CARD_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[CARD_W-1]};
    end else if (ctrl.digit_shift) begin
      bcd <= {4'd0, bcd[BCD_W-1:4]};
    end
  end

  assign digit = bcd[3:0];

endmodule

// ===== design/luhn_scan.sv =====
// Digit scanner: runs the Luhn sum modulo ten, the digit count and the
// leading two digits over digits arriving least significant first.
// Depends on luhn_pkg.
module luhn_scan
  import luhn_pkg::*;
(
  input  logic         clk,
  input  logic         clear,
  input  logic         step,
  input  logic [3:0]   digit,
  output scan_result_t result
);

  logic [POS_W-1:0] pos;
  logic [3:0]       prev;
  logic [4:0]       dbl;
  logic [3:0]       contrib;
  logic [4:0]       sum_raw;
  logic [3:0]       sum_next;

  // Odd positions add the digit sum of twice the digit.
  always_comb begin
    dbl = {digit, 1'b0};
    if (pos[0]) begin
      if (dbl >= 5'd10) begin
        contrib = 4'(dbl - 5'd9);
      end else begin
        contrib = dbl[3:0];
      end
    end else begin
      contrib = digit;
    end
    sum_raw = {1'b0, result.sum_mod10} + {1'b0, contrib};
    if (sum_raw >= 5'd10) begin
      sum_next = 4'(sum_raw - 5'd10);
    end else begin
      sum_next = sum_raw[3:0];
    end
  end

  // The highest nonzero digit seen so far fixes the count and the lead pair.
  always_ff @(posedge clk) begin
    if (clear) begin
      pos    <= '0;
      prev   <= '0;
      result <= '0;
    end else if (step) begin
      pos              <= pos + 1'b1;
      prev             <= digit;
      result.sum_mod10 <= sum_next;
      if (digit != 4'd0) begin
        result.ndig    <= pos + 1'b1;
        result.lead_hi <= digit;
        result.lead_lo <= prev;
      end
    end
  end

endmodule

// ===== design/luhn_card_number_classifier_unit.sv =====
// Channel | Signals                      | Item contents
// input   | s_tvalid s_tready s_tdata    | card_number
// output  | m_tvalid m_tready m_tdata    | card_kind, checksum_ok
//
// Each item is loaded, then takes 54 bit-serial shift and add three
// steps in the BCD converter, 17 digit steps in the scanner and one to decide.
// Reset (rst, synchronous) empties the output register and returns to idle.
// A new item is taken while an earlier result waits in the output register;
// the block holds in its final state only while that register is still full.
// Top level of the Luhn card number classifier.
// Depends on luhn_pkg, luhn_bcd_conv, luhn_scan and the defines header.
`include "luhn_card_number_classifier_unit_defines.svh"
module luhn_card_number_classifier_unit
  import luhn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [53:0] card_number, [55:54] zero
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [1:0] card_kind, [2] checksum_ok, [7:3] zero
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t       state;
  state_t       state_next;
  logic [5:0]   count;
  logic [5:0]   count_next;
  conv_ctrl_t   conv_ctrl;
  logic [3:0]   digit;
  scan_result_t scan;
  logic         accept;
  logic         finish;
  logic         ok;
  logic         lead_four;
  logic         lead_five;
  logic         lead_three;
  logic [1:0]   kind;
  logic [1:0]   card_kind;
  logic         checksum_ok;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign finish   = (state == ST_DONE) && (!m_tvalid || m_tready);

  // Sequencer: conversion steps, then digit steps, then result.
  always_comb begin
    state_next = state;
    count_next = count;
    conv_ctrl  = '0;
    case (state)
      ST_IDLE: begin
        conv_ctrl.load = accept;
        if (accept) begin
          state_next = ST_CONV;
          count_next = '0;
        end
      end
      ST_CONV: begin
        conv_ctrl.dabble = 1'b1;
        count_next       = count + 1'b1;
        if (count == 6'(CARD_W - 1)) begin
          state_next = ST_SCAN;
          count_next = '0;
        end
      end
      ST_SCAN: begin
        conv_ctrl.digit_shift = 1'b1;
        count_next            = count + 1'b1;
        if (count == 6'(NUM_DIGITS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  luhn_bcd_conv u_conv (
    .clk         (clk),
    .card_number (s_tdata[CARD_W-1:0]),
    .ctrl        (conv_ctrl),
    .digit       (digit)
  );

  luhn_scan u_scan (
    .clk    (clk),
    .clear  (conv_ctrl.load),
    .step   (conv_ctrl.digit_shift),
    .digit  (digit),
    .result (scan)
  );

  // Classify from the digit count and the leading two digits.
  always_comb begin
    ok         = (scan.ndig != '0) && (scan.sum_mod10 == 4'd0);
    lead_four  = (scan.lead_hi == 4'd4);
    lead_five  = (scan.lead_hi == 4'd5) && (scan.lead_lo >= 4'd1) &&
                 (scan.lead_lo <= 4'd5);
    lead_three = (scan.lead_hi == 4'd3) &&
                 ((scan.lead_lo == 4'd4) || (scan.lead_lo == 4'd7));
    kind = KIND_INVALID;
    if (ok) begin
      if (((scan.ndig == 5'd13) || (scan.ndig == 5'd16)) && lead_four) begin
        kind = KIND_FOUR;
      end else if ((scan.ndig == 5'd16) && lead_five) begin
        kind = KIND_FIVE;
      end else if ((scan.ndig == 5'd15) && lead_three) begin
        kind = KIND_THREE;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      card_kind   <= kind;
      checksum_ok <= ok;
    end
  end

  assign m_tdata = {5'd0, checksum_ok, card_kind};

  // A network kind is only ever reported with a passing checksum.
  `LCC_ASSERT_IMPLY(a_kind_needs_ok, clk, rst, m_tvalid && (m_tdata[1:0] != KIND_INVALID),
                    m_tdata[2], "card kind set without passing checksum")
  // An accepted item starts the conversion at step zero.
  `LCC_ASSERT_NEXT(a_accept_starts, clk, rst, accept,
                   (state == ST_CONV) && (count == 6'd0), "conversion did not start")
  // The scan never runs past the last digit.
  `LCC_ASSERT_IMPLY(a_scan_bound, clk, rst, state == ST_SCAN,
                    count < 6'(NUM_DIGITS), "digit scan overran")

endmodule

// ===== dv/luhn_card_number_classifier_unit_checker.sv =====
// Scoreboard for the Luhn card number classifier: predicts each verdict from the card
// number taken on the input channel and compares it with the output channel.
// Depends on luhn_pkg.
module luhn_card_number_classifier_unit_checker
  import luhn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     pending,
  output int                     failures
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  typedef struct {
    logic [CARD_W-1:0] card;
    logic [1:0]        kind;
    logic              checksum_ok;
  } card_verdict_t;

  card_verdict_t expected_verdicts[$];
  int cards_taken    = 0;
  int verdicts_seen  = 0;
  int mismatches     = 0;

  // Counters move at the clock edge, so the stimulus side reads settled values.
  assign pending  = cards_taken - verdicts_seen;
  assign failures = mismatches;

  // Luhn digit sum, digit count and leading two digits decide the verdict.
  function automatic card_verdict_t classify_card(input logic [CARD_W-1:0] card);
    card_verdict_t     verdict;
    longint unsigned   rest;
    longint unsigned   lead;
    int unsigned       digit;
    int unsigned       doubled;
    int unsigned       luhn_sum;
    int unsigned       digit_count;
    rest        = card;
    luhn_sum    = 0;
    digit_count = 0;
    while (rest != 0) begin
      digit = rest % 10;
      if (digit_count % 2 == 0) begin
        luhn_sum += digit;
      end else begin
        doubled = 2 * digit;
        luhn_sum += doubled / 10 + doubled % 10;
      end
      rest = rest / 10;
      digit_count++;
    end
    lead = card;
    while (lead >= 100) begin
      lead = lead / 10;
    end
    verdict.card        = card;
    verdict.checksum_ok = (card != 0) && (luhn_sum % 10 == 0);
    verdict.kind        = KIND_INVALID;
    if (verdict.checksum_ok) begin
      if ((digit_count == 13 || digit_count == 16) && lead >= 40 && lead <= 49) begin
        verdict.kind = KIND_FOUR;
      end else if (digit_count == 16 && lead >= 51 && lead <= 55) begin
        verdict.kind = KIND_FIVE;
      end else if (digit_count == 15 && (lead == 34 || lead == 37)) begin
        verdict.kind = KIND_THREE;
      end
    end
    return verdict;
  endfunction

  // One line per mismatch; printing stops after a while but counting goes on.
  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // Record each accepted card and check each accepted verdict against the oldest one.
  always @(posedge clk) begin
    card_verdict_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_verdicts.push_back(classify_card(s_tdata[CARD_W-1:0]));
        cards_taken <= cards_taken + 1;
      end
      if (m_tvalid && m_tready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict 0x%02h with no card outstanding", m_tdata));
        end else begin
          want = expected_verdicts.pop_front();
          if (m_tdata[1:0] !== want.kind) begin
            report_mismatch($sformatf("card %0d: card_kind %0d, expected %0d",
                                      want.card, m_tdata[1:0], want.kind));
          end
          if (m_tdata[2] !== want.checksum_ok) begin
            report_mismatch($sformatf("card %0d: checksum_ok %0b, expected %0b",
                                      want.card, m_tdata[2], want.checksum_ok));
          end
        end
      end
    end
  end

endmodule

// ===== dv/luhn_card_number_classifier_unit_tb.sv =====
// Top of the Luhn card number classifier testbench: clock, reset, card number
// stimulus, output back-pressure, watchdog and verdict.
// Depends on luhn_pkg, the block and luhn_card_number_classifier_unit_checker.
module luhn_card_number_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import luhn_pkg::*;

  localparam int              RANDOM_CARDS  = 1600;
  localparam int              IDLE_LIMIT    = 4000;
  localparam int              SETTLE_CYCLES = 100;
  localparam longint unsigned DIGITS16_SPAN = 64'd10000000000000000;

  // Receiver back-pressure patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic                   clk;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     pending;
  int                     failures;

  rx_mode_t   rx_mode     = RX_OPEN;
  logic [8:0] rx_phase    = '0;
  int         idle_cycles = 0;
  int         burst_left  = 1;
  bit         holding     = 1'b0;

  luhn_card_number_classifier_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  luhn_card_number_classifier_unit_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pending  (pending),
    .failures (failures)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: a new stall pattern each time the 9-bit phase counter wraps.
  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase == '0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
    end
    case (rx_mode)
      RX_OPEN: begin
        m_tready <= 1'b1;
      end
      RX_COIN: begin
        m_tready <= $urandom_range(0, 1);
      end
      RX_SPARSE: begin
        m_tready <= ($urandom_range(0, 15) == 0);
      end
      default: begin
        m_tready <= rx_phase[6];
      end
    endcase
  end

  // Watchdog: too long without any item moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Card number of a given length and leading pair; the check digit is chosen so the
  // Luhn rule holds, or is deliberately off by a random amount.
  function automatic logic [CARD_W-1:0] make_card(input int unsigned lead,
                                                  input int unsigned len,
                                                  input bit luhn_good);
    int unsigned     digit_at[17];
    int unsigned     doubled_sum[10] = '{0, 2, 4, 6, 8, 1, 3, 5, 7, 9};
    int unsigned     partial;
    int unsigned     check;
    longint unsigned value;
    for (int i = 0; i < len; i++) begin
      digit_at[i] = $urandom_range(0, 9);
    end
    digit_at[len-1] = lead / 10;
    digit_at[len-2] = lead % 10;
    partial = 0;
    for (int i = 1; i < len; i++) begin
      partial += (i % 2 == 1) ? doubled_sum[digit_at[i]] : digit_at[i];
    end
    check = (10 - partial % 10) % 10;
    if (!luhn_good) begin
      check = (check + $urandom_range(1, 9)) % 10;
    end
    digit_at[0] = check;
    value = 0;
    for (int i = len - 1; i >= 0; i--) begin
      value = value * 10 + digit_at[i];
    end
    return value;
  endfunction

  // Present one card and hold it until taken; bursts end in a random gap.
  task automatic send_card(input logic [CARD_W-1:0] card);
    s_tdata  <= {{(IN_TDATA_W - CARD_W){1'b0}}, card};
    s_tvalid <= 1'b1;
    holding = 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      holding = 1'b0;
      repeat ($urandom_range(1, 120)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                : $urandom_range(1, 6);
    end
  endtask

  // Stop sending until every outstanding verdict has been delivered.
  task automatic wait_all_delivered();
    if (holding) begin
      s_tvalid <= 1'b0;
      holding = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
  endtask

  // Well-formed numbers dominate; others are raw: full field, < 10^16, or 0 to 999.
  function automatic logic [CARD_W-1:0] random_card();
    int unsigned       near_edges[7] = '{33, 35, 36, 38, 39, 50, 56};
    int unsigned       len;
    int unsigned       lead;
    int unsigned       pick;
    logic [CARD_W-1:0] raw;
    pick = $urandom_range(0, 99);
    raw  = {$urandom, $urandom};
    if (pick < 65) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = 16;
        3, 4:    len = 15;
        5, 6:    len = 13;
        7:       len = 17;
        8:       len = $urandom_range(2, 12);
        default: len = 14;
      endcase
      case ($urandom_range(0, 5))
        0:       lead = $urandom_range(40, 49);
        1:       lead = $urandom_range(51, 55);
        2:       lead = $urandom_range(0, 1) ? 34 : 37;
        3:       lead = $urandom_range(10, 99);
        4:       lead = near_edges[$urandom_range(0, 6)];
        default: lead = $urandom_range(40, 55);
      endcase
      // Seventeen digits always fit in the field with a leading pair up to 17.
      if (len == 17) begin
        lead = $urandom_range(10, 17);
      end
      return make_card(lead, len, $urandom_range(0, 9) != 0);
    end else if (pick < 80) begin
      return raw;
    end else if (pick < 92) begin
      return 64'(raw) % DIGITS16_SPAN;
    end else begin
      return $urandom_range(0, 999);
    end
  endfunction

  initial begin
    logic [CARD_W-1:0] directed_cards[$];
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Extremes, short numbers, every kind and the edges of each prefix range.
    directed_cards = '{0, 1, 59, 99, 100, {CARD_W{1'b1}},
                       DIGITS16_SPAN - 1, DIGITS16_SPAN};
    directed_cards.push_back(make_card(40, 13, 1'b1));
    directed_cards.push_back(make_card(49, 16, 1'b1));
    directed_cards.push_back(make_card(45, 14, 1'b1));
    directed_cards.push_back(make_card(39, 16, 1'b1));
    directed_cards.push_back(make_card(50, 16, 1'b1));
    directed_cards.push_back(make_card(51, 16, 1'b1));
    directed_cards.push_back(make_card(55, 16, 1'b1));
    directed_cards.push_back(make_card(56, 16, 1'b1));
    directed_cards.push_back(make_card(52, 15, 1'b1));
    directed_cards.push_back(make_card(34, 15, 1'b1));
    directed_cards.push_back(make_card(37, 15, 1'b1));
    directed_cards.push_back(make_card(35, 15, 1'b1));
    directed_cards.push_back(make_card(37, 16, 1'b1));
    directed_cards.push_back(make_card(44, 16, 1'b0));
    directed_cards.push_back(make_card(34, 15, 1'b0));
    directed_cards.push_back(make_card(12, 17, 1'b1));
    foreach (directed_cards[i]) begin
      send_card(directed_cards[i]);
    end
    wait_all_delivered();

    // Random part, with one full drain halfway through.
    for (int n = 0; n < RANDOM_CARDS; n++) begin
      send_card(random_card());
      if (n == RANDOM_CARDS / 2) begin
        wait_all_delivered();
      end
    end

    wait_all_delivered();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
